// ===== hw/rtl/fopalu_pkg.sv =====
// shared types and constants for the four-operation alu
`default_nettype none

package fopalu_pkg;

  // default datapath width
  localparam int OPERAND_WIDTH_DEF = 16;

  // field widths of the words on the ports
  localparam int OPCODE_BITS    = 2;
  localparam int FIELD_BITS     = 16;
  localparam int RESULT_BITS    = 33;
  localparam int REMAINDER_BITS = 16;

  // opcodes
  localparam logic [OPCODE_BITS-1:0] OP_SUM = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_SUB = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_MUL = 2'd2;
  localparam logic [OPCODE_BITS-1:0] OP_DIV = 2'd3;

  // request word
  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [FIELD_BITS-1:0]  operand_a;
    logic [FIELD_BITS-1:0]  operand_b;
  } req_t;

  // response word
  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result;
    logic [REMAINDER_BITS-1:0]     remainder;
    logic                          divide_by_zero;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/four_op_alu_iterative_muldiv_unit.sv =====
// four-operation alu top level: add, subtract, shift-add multiply, restoring divide
//
// Takes one request word (opcode, operand_a, operand_b) and returns one response word
// (result, remainder, divide_by_zero). Operands are cut or zero-extended to
// OPERAND_WIDTH bits; the result is the low 33 bits of the two's complement value and
// the remainder the low 16 bits. All four operations share one (OPERAND_WIDTH+2)-bit
// adder/subtractor under a small sequencer. Multiply and divide take one adder pass
// per operand bit; add and subtract take a single pass, and a divide by zero goes
// straight to the done state without one. A finished result waits in the sequencer
// for as long as the output register still holds an unaccepted response. The block
// takes one request at a time: req_ready is high only while the sequencer is idle,
// which it becomes again as the response is registered, so a new request is taken
// only once the previous one is finished. It may take the next request while the
// previous response still waits in the output register. A zero divisor gives
// quotient 0, remainder equal to operand_a and sets divide_by_zero.
`default_nettype none

module four_op_alu_iterative_muldiv_unit #(
  parameter int OPERAND_WIDTH = fopalu_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire fopalu_pkg::req_t  req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output fopalu_pkg::rsp_t       rsp
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam int FW = (2 * W > fopalu_pkg::RESULT_BITS) ? 2 * W : fopalu_pkg::RESULT_BITS;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                        state;
  logic [fopalu_pkg::OPCODE_BITS-1:0] op;
  logic [W-1:0]                      acc;
  logic [W-1:0]                      lo;
  logic [W-1:0]                      opb;
  logic                              dz;
  logic [CW-1:0]                     cnt;

  logic [W-1:0]   in_a;
  logic [W-1:0]   in_b;
  logic           take;
  logic [W:0]     add_x;
  logic [W:0]     add_y;
  logic [W:0]     add_y_sel;
  logic           add_sub;
  logic [W+1:0]   add_out;
  logic           last_step;
  logic [FW-1:0]  res_full;
  logic [fopalu_pkg::REMAINDER_BITS-1:0] rem_val;
  logic           out_free;

  assign in_a      = W'(req.operand_a);
  assign in_b      = W'(req.operand_b);
  assign req_ready = (state == ST_IDLE);
  assign take      = req_valid && req_ready;
  assign last_step = (cnt == CW'(W - 1));
  assign out_free  = !rsp_valid || rsp_ready;

  // operand select for the shared adder
  always_comb begin
    case (op)
      fopalu_pkg::OP_SUM: begin
        add_x   = {1'b0, lo};
        add_y   = {1'b0, opb};
        add_sub = 1'b0;
      end
      fopalu_pkg::OP_SUB: begin
        add_x   = {1'b0, lo};
        add_y   = {1'b0, opb};
        add_sub = 1'b1;
      end
      fopalu_pkg::OP_MUL: begin
        add_x   = {1'b0, acc};
        add_y   = lo[0] ? {1'b0, opb} : '0;
        add_sub = 1'b0;
      end
      default: begin
        add_x   = {acc, lo[W-1]};
        add_y   = {1'b0, opb};
        add_sub = 1'b1;
      end
    endcase
  end

  // shared adder/subtractor, top bit is carry (no borrow on subtract)
  assign add_y_sel = add_sub ? ~add_y : add_y;
  assign add_out   = {1'b0, add_x} + {1'b0, add_y_sel} + (W+2)'(add_sub);

  // final value from the datapath registers
  always_comb begin
    case (op)
      fopalu_pkg::OP_SUM: res_full = FW'({acc[0], lo});
      fopalu_pkg::OP_SUB: res_full = FW'($signed({acc[0], lo}));
      fopalu_pkg::OP_MUL: res_full = FW'({acc, lo});
      default:            res_full = FW'(lo);
    endcase
    rem_val = (op == fopalu_pkg::OP_DIV) ? fopalu_pkg::REMAINDER_BITS'(acc) : '0;
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            op  <= req.opcode;
            cnt <= '0;
            dz  <= 1'b0;
            acc <= '0;
            if (req.opcode == fopalu_pkg::OP_MUL) begin
              opb <= in_a;
              lo  <= in_b;
            end else begin
              opb <= in_b;
              lo  <= in_a;
            end
            // zero divisor finishes at once
            if (req.opcode == fopalu_pkg::OP_DIV && in_b == '0) begin
              dz    <= 1'b1;
              acc   <= in_a;
              lo    <= '0;
              state <= ST_DONE;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          case (op)
            fopalu_pkg::OP_MUL: begin
              acc <= add_out[W:1];
              lo  <= {add_out[0], lo[W-1:1]};
            end
            fopalu_pkg::OP_DIV: begin
              if (add_out[W+1]) begin
                acc <= add_out[W-1:0];
              end else begin
                acc <= add_x[W-1:0];
              end
              lo <= {lo[W-2:0], add_out[W+1]};
            end
            default: begin
              acc <= W'(add_out[W]);
              lo  <= add_out[W-1:0];
            end
          endcase
          cnt <= cnt + 1'b1;
          if (op == fopalu_pkg::OP_SUM || op == fopalu_pkg::OP_SUB || last_step) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_valid          <= 1'b1;
      rsp.result         <= res_full[fopalu_pkg::RESULT_BITS-1:0];
      rsp.remainder      <= rem_val;
      rsp.divide_by_zero <= dz;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
